@@ rtl/vafm_pkg.sv @@
package vafm_pkg;

    // Default number of aiding sources held in the innovation table.
    localparam int NUM_SOURCES_DEF = 6;

    // Field widths fixed by the item formats.
    localparam int IDX_W     = 3;
    localparam int INNOV_W   = 32;
    localparam int VAR_W     = 32;
    localparam int AXES      = 3;
    localparam int TIME_W    = 64;
    localparam int LIMIT_W   = 10;
    localparam int PROB_W    = 26;
    localparam int THR_W     = 16;
    localparam int THR_SQ_W  = 2 * THR_W;
    localparam int PROD_W    = 64;
    localparam int LIK_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 26;
    localparam int S_DATA_W  = 136;
    localparam int M_DATA_W  = 8;

    // Register reset values.
    localparam logic [LIMIT_W-1:0]  CLIP_LIMIT_RST = 10'd100;
    localparam logic [PROB_W-1:0]   PROBATION_RST  = 26'd10000000;
    localparam logic [THR_SQ_W-1:0] TEST_MIN_SQ_RST = 32'd65536;   // 256 squared
    localparam logic [THR_SQ_W-1:0] TEST_LIM_SQ_RST = 32'd589824;  // 768 squared

    // The range source measures distance to ground, so its innovation is negated.
    localparam logic [IDX_W-1:0] RANGE_SOURCE = 3'd3;

    localparam logic [INNOV_W-1:0] INNOV_MOST_NEG = 32'h8000_0000;
    localparam logic [INNOV_W-1:0] INNOV_MOST_POS = 32'h7FFF_FFFF;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_IMU  = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_LIMIT = 2'd0,
        CFG_PROBATION  = 2'd1,
        CFG_TEST_MIN   = 2'd2,
        CFG_TEST_LIM   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_PRESSURE = 2'd0,
        KIND_GNSS     = 2'd1,
        KIND_GROUND   = 2'd2
    } ref_kind_t;

    typedef enum logic [LIK_W-1:0] {
        LIK_LOW    = 2'd0,
        LIK_MEDIUM = 2'd1,
        LIK_HIGH   = 2'd2
    } likelihood_t;

    // Reference type of each source slot: barometer, then two GNSS slots, then ground.
    function automatic ref_kind_t ref_kind(input logic [IDX_W-1:0] idx);
        ref_kind_t k;
        unique case (idx)
            3'd0:       k = KIND_PRESSURE;
            3'd1, 3'd2: k = KIND_GNSS;
            default:    k = KIND_GROUND;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/vertical_accel_fault_monitor.sv @@
// Channel   Direction  Handshake                 Payload
// s_        in         s_tvalid / s_tready       s_tuser opcode, s_tdata source entry or IMU sample
// m_        out        m_tvalid / m_tready       m_tdata fault flags and falling likelihood
// cfg_      in         cfg_valid / cfg_ready     cfg_index register number, cfg_data value
//
// Every input beat passes a capture register and a product register, and an IMU
// result then the result register. One beat is taken per cycle unless a stall
// or re-grade holds s_tready low; the three multipliers of the ratio test fill the product stage.
// Reset is synchronous on aresetn low and clears the table, counters and flags.
// A stalled result only holds the pipeline once every stage behind it is full.
// A write of either test threshold re-grades the stored sources, one per cycle
// while the pipeline is not held; s_tready is low throughout the sweep.
module vertical_accel_fault_monitor
    import vafm_pkg::*;
#(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] opcode
    input  logic                  s_tuser,
    // [2:0] source_index, [3] source_active, [35:4] innovation,
    // [67:36] innovation_var, [70:68] clip_flags, [134:71] sample_time_us,
    // [135] zero fill
    input  logic [S_DATA_W-1:0]   s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] bad_clipping, [1] bad_vertical, [3:2] falling_likelihood, [7:4] zero
    output logic [M_DATA_W-1:0]   m_tdata,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data
);

    localparam int SRC_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam logic [SRC_W-1:0] LAST_SRC = SRC_W'(NUM_SOURCES - 1);

    // ------------------------------------------------------------------
    // Configuration registers. Thresholds are kept squared, since the
    // ratio test only ever uses the square.
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0]  clip_limit_reg;
    logic [PROB_W-1:0]   probation_reg;
    logic [THR_SQ_W-1:0] test_min_sq_reg;
    logic [THR_SQ_W-1:0] test_lim_sq_reg;
    logic [THR_W-1:0]    cfg_thr;
    logic                cfg_wr;
    logic                thr_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_thr   = cfg_data[THR_W-1:0];
    assign thr_wr    = cfg_wr && (cfg_index == CFG_TEST_MIN || cfg_index == CFG_TEST_LIM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_limit_reg  <= CLIP_LIMIT_RST;
            probation_reg   <= PROBATION_RST;
            test_min_sq_reg <= TEST_MIN_SQ_RST;
            test_lim_sq_reg <= TEST_LIM_SQ_RST;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                CFG_CLIP_LIMIT: clip_limit_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_PROBATION:  probation_reg   <= cfg_data[PROB_W-1:0];
                CFG_TEST_MIN:   test_min_sq_reg <= cfg_thr * cfg_thr;
                CFG_TEST_LIM:   test_lim_sq_reg <= cfg_thr * cfg_thr;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Source table: stored entry plus the pass/fail result of both ratio
    // tests, graded once when the entry is loaded or re-graded.
    // ------------------------------------------------------------------
    logic [INNOV_W-1:0] src_innov_reg [NUM_SOURCES];
    logic [VAR_W-1:0]   src_var_reg   [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] src_active_reg;
    logic [NUM_SOURCES-1:0] fail_min_reg;
    logic [NUM_SOURCES-1:0] fail_lim_reg;

    // Re-grade sweep after a threshold write.
    logic             sweep_active_reg;
    logic [SRC_W-1:0] sweep_idx_reg;

    // ------------------------------------------------------------------
    // Pipeline control. Stage 1 holds the captured beat, stage 2 the
    // products of the ratio test.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic out_ok, s2_adv, s2_ready, s1_adv, s1_ready, s_acc, sweep_inj;

    // Stage 1 payload
    opcode_t            s1_op_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_active_reg;
    logic [INNOV_W-1:0] s1_innov_reg;
    logic [VAR_W-1:0]   s1_var_reg;
    logic [AXES-1:0]    s1_clip_reg;
    logic [TIME_W-1:0]  s1_time_reg;

    // Stage 2 payload
    opcode_t            s2_op_reg;
    logic [IDX_W-1:0]   s2_idx_reg;
    logic               s2_active_reg;
    logic               s2_pos_reg;
    logic [INNOV_W-1:0] s2_innov_reg;
    logic [VAR_W-1:0]   s2_var_reg;
    logic [AXES-1:0]    s2_clip_reg;
    logic [TIME_W-1:0]  s2_time_reg;
    logic [PROD_W-1:0]  s2_sq_reg;
    logic [PROD_W-1:0]  s2_min_reg;
    logic [PROD_W-1:0]  s2_lim_reg;

    assign out_ok    = !m_valid_reg || m_tready;
    assign s2_adv    = s2_valid_reg && (s2_op_reg == OP_LOAD || out_ok);
    assign s2_ready  = !s2_valid_reg || s2_adv;
    assign s1_adv    = s1_valid_reg && s2_ready;
    assign s1_ready  = !s1_valid_reg || s1_adv;
    assign s_tready  = s1_ready && !sweep_active_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign sweep_inj = sweep_active_reg && s1_ready;

    // Unpack the input beat and fold the range sign flip in at capture.
    logic [IDX_W-1:0]   in_idx;
    logic [INNOV_W-1:0] in_innov;
    logic [INNOV_W-1:0] in_innov_adj;

    assign in_idx   = s_tdata[2:0];
    assign in_innov = s_tdata[35:4];

    always_comb begin
        in_innov_adj = in_innov;
        if (in_idx == RANGE_SOURCE) begin
            in_innov_adj = (in_innov == INNOV_MOST_NEG) ? INNOV_MOST_POS : (~in_innov + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_active_reg <= 1'b0;
            sweep_idx_reg    <= '0;
        end else if (thr_wr) begin
            sweep_active_reg <= 1'b1;
            sweep_idx_reg    <= '0;
        end else if (sweep_inj) begin
            if (sweep_idx_reg == LAST_SRC) begin
                sweep_active_reg <= 1'b0;
            end else begin
                sweep_idx_reg <= sweep_idx_reg + 1'b1;
            end
        end
    end

    // Stage 1 capture: a stream beat or a re-grade of a stored entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_acc || sweep_inj || (s1_valid_reg && !s1_adv);
        end
    end

    always_ff @(posedge aclk) begin
        if (sweep_inj) begin
            s1_op_reg     <= OP_LOAD;
            s1_idx_reg    <= IDX_W'(sweep_idx_reg);
            s1_active_reg <= src_active_reg[sweep_idx_reg];
            s1_innov_reg  <= src_innov_reg[sweep_idx_reg];
            s1_var_reg    <= src_var_reg[sweep_idx_reg];
        end else if (s_acc) begin
            s1_op_reg     <= opcode_t'(s_tuser);
            s1_idx_reg    <= in_idx;
            s1_active_reg <= s_tdata[3];
            s1_innov_reg  <= in_innov_adj;
            s1_var_reg    <= s_tdata[67:36];
            s1_clip_reg   <= s_tdata[70:68];
            s1_time_reg   <= s_tdata[134:71];
        end
    end

    // Stage 2: innov^2 and threshold^2 * variance side by side.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_adv || (s2_valid_reg && !s2_adv);
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_op_reg     <= s1_op_reg;
            s2_idx_reg    <= s1_idx_reg;
            s2_active_reg <= s1_active_reg;
            s2_pos_reg    <= !s1_innov_reg[INNOV_W-1] && (s1_innov_reg != '0);
            s2_innov_reg  <= s1_innov_reg;
            s2_var_reg    <= s1_var_reg;
            s2_clip_reg   <= s1_clip_reg;
            s2_time_reg   <= s1_time_reg;
            s2_sq_reg     <= s1_innov_reg * s1_innov_reg;
            s2_min_reg    <= s1_var_reg * test_min_sq_reg;
            s2_lim_reg    <= s1_var_reg * test_lim_sq_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 combinational work: finish the ratio test of a load beat,
    // or grade and update the fault state for an IMU beat.
    // ------------------------------------------------------------------
    logic            s2_usable, s2_fail_min, s2_fail_lim, s2_wr;
    logic [SRC_W-1:0] s2_slot;

    assign s2_usable   = s2_active_reg && (s2_var_reg != '0) && s2_pos_reg;
    assign s2_fail_min = s2_usable && (s2_sq_reg > s2_min_reg);
    assign s2_fail_lim = s2_usable && (s2_sq_reg > s2_lim_reg);
    assign s2_slot     = s2_idx_reg[SRC_W-1:0];
    assign s2_wr       = s2_adv && (s2_op_reg == OP_LOAD)
                         && ({1'b0, s2_idx_reg} < (IDX_W+1)'(NUM_SOURCES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_active_reg <= '0;
            fail_min_reg   <= '0;
            fail_lim_reg   <= '0;
            for (int i = 0; i < NUM_SOURCES; i++) begin
                src_innov_reg[i] <= '0;
                src_var_reg[i]   <= '0;
            end
        end else if (s2_wr) begin
            src_active_reg[s2_slot] <= s2_active_reg;
            src_innov_reg[s2_slot]  <= s2_innov_reg;
            src_var_reg[s2_slot]    <= s2_var_reg;
            fail_min_reg[s2_slot]   <= s2_fail_min;
            fail_lim_reg[s2_slot]   <= s2_fail_lim;
        end
    end

    // Likelihood: medium when any source fails the limit test, high when
    // another reference type also fails the minimum test at the same time.
    likelihood_t lik;
    logic        lik_high;

    always_comb begin
        lik_high = 1'b0;
        for (int a = 0; a < NUM_SOURCES; a++) begin
            for (int b = 0; b < NUM_SOURCES; b++) begin
                if (fail_lim_reg[a] && fail_min_reg[b]
                    && ref_kind(IDX_W'(a)) != ref_kind(IDX_W'(b))) begin
                    lik_high = 1'b1;
                end
            end
        end
        if (lik_high) begin
            lik = LIK_HIGH;
        end else if (|fail_lim_reg) begin
            lik = LIK_MEDIUM;
        end else begin
            lik = LIK_LOW;
        end
    end

    // Saturating up/down clip counters.
    logic [LIMIT_W-1:0] clip_count_reg  [AXES];
    logic [LIMIT_W-1:0] clip_count_next [AXES];
    logic [LIMIT_W-1:0] half_limit;
    logic [AXES-1:0]    warn, crit;

    assign half_limit = clip_limit_reg >> 1;

    always_comb begin
        for (int ax = 0; ax < AXES; ax++) begin
            if (s2_clip_reg[ax] && clip_count_reg[ax] < clip_limit_reg) begin
                clip_count_next[ax] = clip_count_reg[ax] + 1'b1;
            end else if (clip_count_reg[ax] != '0) begin
                clip_count_next[ax] = clip_count_reg[ax] - 1'b1;
            end else begin
                clip_count_next[ax] = clip_count_reg[ax];
            end
            warn[ax] = clip_count_next[ax] >= half_limit;
            crit[ax] = clip_count_next[ax] >= clip_limit_reg;
        end
    end

    // Vertical fault: a bad sample restamps the time; a set fault is held
    // while the sample is within probation of that stamp (or earlier).
    logic              bad_clip, frequent, bad_now, recent;
    logic              bad_vertical_reg, bad_vertical_next;
    logic [TIME_W-1:0] last_bad_time_reg, last_bad_eff, since_bad;
    logic              imu_step;

    assign imu_step     = s2_adv && (s2_op_reg == OP_IMU);
    assign bad_clip     = (&warn) || (|crit);
    assign frequent     = warn[AXES-1] || bad_clip;
    assign bad_now      = (frequent && lik == LIK_MEDIUM) || lik == LIK_HIGH;
    assign last_bad_eff = bad_now ? s2_time_reg : last_bad_time_reg;
    assign since_bad    = s2_time_reg - last_bad_eff;
    assign recent       = (s2_time_reg < last_bad_eff)
                          || ((since_bad[TIME_W-1:PROB_W] == '0)
                              && (since_bad[PROB_W-1:0] < probation_reg));
    assign bad_vertical_next = bad_vertical_reg ? recent : bad_now;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bad_vertical_reg  <= 1'b0;
            last_bad_time_reg <= '0;
            for (int ax = 0; ax < AXES; ax++) begin
                clip_count_reg[ax] <= '0;
            end
        end else if (imu_step) begin
            bad_vertical_reg  <= bad_vertical_next;
            last_bad_time_reg <= last_bad_eff;
            for (int ax = 0; ax < AXES; ax++) begin
                clip_count_reg[ax] <= clip_count_next[ax];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic [M_DATA_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (imu_step) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (imu_step) begin
            m_data_reg <= {4'b0000, lik, bad_vertical_next, bad_clip};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ test/tb_vertical_accel_fault_monitor.sv @@
module tb_vertical_accel_fault_monitor;
    timeunit 1ns;
    timeprecision 1ps;

    import vafm_pkg::*;

    localparam int NSRC            = NUM_SOURCES_DEF;
    localparam int PHASES          = 7;
    localparam int BEATS_PER_PHASE = 170;
    // Idle cycles after the last result, for load beats still in the pipeline.
    localparam int DRAIN_CYCLES    = 8;
    localparam int PRINT_CAP       = 200;

    // One input beat, unpacked into its fields.
    typedef struct packed {
        opcode_t             op;
        logic [IDX_W-1:0]    idx;
        logic                active;
        logic [INNOV_W-1:0]  innov;
        logic [VAR_W-1:0]    var_q;
        logic [AXES-1:0]     clips;
        logic [TIME_W-1:0]   t_us;
    } sample_t;

    // One result beat.
    typedef struct packed {
        logic        bad_clip;
        logic        bad_vert;
        likelihood_t lik;
    } fault_t;

    // A directed row: the beat, and a hand-written result where one is given.
    typedef struct packed {
        sample_t s;
        logic    typed;
        fault_t  want;
    } stim_row_t;

    localparam fault_t NO_TYPED = '0;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic                 s_tuser   = OP_LOAD;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_CLIP_LIMIT;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    always #5 aclk = ~aclk;

    vertical_accel_fault_monitor #(
        .NUM_SOURCES(NSRC)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Shadow copy of the monitor: registers, source table, clip counters, fault latch.
    logic [LIMIT_W-1:0] clip_limit_q = 10'd100;
    logic [PROB_W-1:0]  probation_q  = 26'd10000000;
    logic [THR_W-1:0]   test_min_q   = 16'd256;
    logic [THR_W-1:0]   test_lim_q   = 16'd768;
    logic [INNOV_W-1:0] src_innov [NSRC];
    logic [VAR_W-1:0]   src_var [NSRC];
    logic               src_active [NSRC];
    logic [LIMIT_W-1:0] clip_cnt [AXES];
    logic [TIME_W-1:0]  last_bad_us;
    logic               bad_vert_q;

    fault_t             expected_faults [$];
    stim_row_t          dir_rows [$];
    int                 mismatches   = 0;
    int                 results_seen = 0;
    int                 idle_pct     = 25;
    int                 clip_bias    = 50;
    logic [TIME_W-1:0]  stamp_us     = '0;

    task automatic log_mismatch(input string msg);
        mismatches++;
        // Keep the log readable when the block is badly broken.
        if (mismatches <= PRINT_CAP)
            $display("[%0t ns] mismatch: %s", $time, msg);
    endtask

    function automatic ref_kind_t kind_of(input int slot);
        if (slot == 0)
            return KIND_PRESSURE;
        return (slot < 3) ? KIND_GNSS : KIND_GROUND;
    endfunction

    // Ratio test on raw integers: positive innovation whose square beats thr^2 * var.
    function automatic logic ratio_fails(input logic [INNOV_W-1:0] innov,
                                         input logic [VAR_W-1:0] var_q,
                                         input logic [THR_W-1:0] thr);
        logic [63:0] lhs;
        logic [63:0] rhs;
        if (innov == '0 || innov[INNOV_W-1])
            return 1'b0;
        lhs = {32'd0, innov} * {32'd0, innov};
        rhs = ({48'd0, thr} * {48'd0, thr}) * {32'd0, var_q};
        return lhs > rhs;
    endfunction

    // Advances the shadow state by one beat; returns 1 with the result for an IMU beat.
    function automatic logic predict_beat(input sample_t it, output fault_t res);
        logic [INNOV_W-1:0] stored;
        logic [LIMIT_W-1:0] half;
        logic               fail_min [NSRC];
        logic               fail_lim [NSRC];
        logic               any_lim;
        logic               cross_kind;
        logic               bad_clip;
        logic               frequent;
        logic               bad_now;
        logic [AXES-1:0]    warn;
        logic [AXES-1:0]    crit;
        likelihood_t        lik;
        res = '0;
        if (it.op == OP_LOAD) begin
            if (it.idx >= NSRC)
                return 1'b0;
            stored = it.innov;
            // Range measures distance to ground, so its sign flips, saturating at the top.
            if (it.idx == RANGE_SOURCE)
                stored = (stored == INNOV_MOST_NEG) ? INNOV_MOST_POS : 32'd0 - stored;
            src_innov[it.idx]  = stored;
            src_var[it.idx]    = it.var_q;
            src_active[it.idx] = it.active;
            return 1'b0;
        end

        // The likelihood is graded from the table before the counters move.
        for (int a = 0; a < NSRC; a++) begin
            fail_min[a] = src_active[a] && src_var[a] != '0 &&
                          ratio_fails(src_innov[a], src_var[a], test_min_q);
            fail_lim[a] = src_active[a] && src_var[a] != '0 &&
                          ratio_fails(src_innov[a], src_var[a], test_lim_q);
        end
        any_lim    = 1'b0;
        cross_kind = 1'b0;
        for (int a = 0; a < NSRC; a++) begin
            if (fail_lim[a]) begin
                any_lim = 1'b1;
                for (int b = 0; b < NSRC; b++)
                    if (fail_min[b] && kind_of(a) != kind_of(b))
                        cross_kind = 1'b1;
            end
        end
        if (cross_kind)
            lik = LIK_HIGH;
        else if (any_lim)
            lik = LIK_MEDIUM;
        else
            lik = LIK_LOW;

        half = clip_limit_q >> 1;
        for (int ax = 0; ax < AXES; ax++) begin
            if (it.clips[ax] && clip_cnt[ax] < clip_limit_q)
                clip_cnt[ax] = clip_cnt[ax] + 1'b1;
            else if (clip_cnt[ax] != '0)
                clip_cnt[ax] = clip_cnt[ax] - 1'b1;
            warn[ax] = clip_cnt[ax] >= half;
            crit[ax] = clip_cnt[ax] >= clip_limit_q;
        end
        bad_clip = (&warn) || (|crit);
        frequent = warn[2] || bad_clip;
        bad_now  = (lik == LIK_HIGH) || (lik == LIK_MEDIUM && frequent);

        if (bad_now)
            last_bad_us = it.t_us;
        // A set fault holds while the sample is recent; a time step backwards counts as recent.
        if (bad_vert_q)
            bad_vert_q = (it.t_us < last_bad_us) ||
                         (it.t_us - last_bad_us < 64'(probation_q));
        else
            bad_vert_q = bad_now;

        res.bad_clip = bad_clip;
        res.bad_vert = bad_vert_q;
        res.lik      = lik;
        return 1'b1;
    endfunction

    // Beat builders; fields the opcode does not use carry random junk.
    function automatic sample_t load_beat(input logic [IDX_W-1:0] idx, input logic active,
                                          input logic [INNOV_W-1:0] innov,
                                          input logic [VAR_W-1:0] var_q);
        sample_t s;
        s.op     = OP_LOAD;
        s.idx    = idx;
        s.active = active;
        s.innov  = innov;
        s.var_q  = var_q;
        s.clips  = AXES'($urandom);
        s.t_us   = {$urandom, $urandom};
        return s;
    endfunction

    function automatic sample_t imu_beat(input logic [AXES-1:0] clips,
                                         input logic [TIME_W-1:0] t_us);
        sample_t s;
        s.op     = OP_IMU;
        s.idx    = IDX_W'($urandom);
        s.active = 1'($urandom);
        s.innov  = $urandom;
        s.var_q  = $urandom;
        s.clips  = clips;
        s.t_us   = t_us;
        return s;
    endfunction

    // Random beat: table loads with magnitudes spread across the ratio thresholds,
    // IMU samples with biased clipping and a mostly forward clock.
    function automatic sample_t random_beat();
        logic [INNOV_W-1:0] mag;
        logic [VAR_W-1:0]   v;
        logic [IDX_W-1:0]   idx;
        logic [AXES-1:0]    clips;
        if ($urandom_range(0, 99) < 40) begin
            mag = $urandom >> $urandom_range(0, 31);
            case ($urandom_range(0, 19))
                0:       mag = INNOV_MOST_NEG;
                1:       mag = '0;
                2, 3, 4: mag = 32'd0 - mag;
                default: ;
            endcase
            case ($urandom_range(0, 9))
                0:       v = '0;
                1:       v = $urandom;
                default: v = $urandom >> $urandom_range(8, 31);
            endcase
            idx = ($urandom_range(0, 15) < 14) ? IDX_W'($urandom_range(0, NSRC - 1))
                                                : IDX_W'($urandom_range(NSRC, 7));
            return load_beat(idx, $urandom_range(0, 9) < 8, mag, v);
        end
        for (int ax = 0; ax < AXES; ax++)
            clips[ax] = $urandom_range(0, 99) < clip_bias;
        case ($urandom_range(0, 19))
            0:       stamp_us = {$urandom, $urandom};
            1:       stamp_us = stamp_us - $urandom_range(0, 50000);
            2:       stamp_us = stamp_us + $urandom_range(0, 70000000);
            default: stamp_us = stamp_us + $urandom_range(1, 3000);
        endcase
        return imu_beat(clips, stamp_us);
    endfunction

    // Offers one beat, waits for the handshake and records what it should produce.
    // The valid is left high after acceptance; the next call or the caller lowers it.
    task automatic send_beat(input sample_t it, input logic typed, input fault_t want);
        fault_t res;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {1'b0, it.t_us, it.clips, it.var_q, it.innov, it.active, it.idx};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (predict_beat(it, res))
            expected_faults.push_back(typed ? want : res);
    endtask

    // Stops offering beats until every pending result is back and the pipe is empty.
    task automatic drain_inputs();
        s_tvalid <= 1'b0;
        while (expected_faults.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input cfg_index_t idx, input logic [CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            CFG_CLIP_LIMIT: clip_limit_q = value[LIMIT_W-1:0];
            CFG_PROBATION:  probation_q  = value[PROB_W-1:0];
            CFG_TEST_MIN:   test_min_q   = value[THR_W-1:0];
            CFG_TEST_LIM:   test_lim_q   = value[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [LIMIT_W-1:0] limit,
                                  input logic [PROB_W-1:0] prob,
                                  input logic [THR_W-1:0] tmin,
                                  input logic [THR_W-1:0] tlim);
        put_reg(CFG_CLIP_LIMIT, CFG_DAT_W'(limit));
        put_reg(CFG_PROBATION, prob);
        put_reg(CFG_TEST_MIN, CFG_DAT_W'(tmin));
        put_reg(CFG_TEST_LIM, CFG_DAT_W'(tlim));
        cfg_valid <= 1'b0;
    endtask

    // Result side: checks every result beat and drives the ready with random stalls.
    // Twice in the run it holds ready low for a long stretch so the pipe backs up.
    initial begin : result_sink
        int     hold_left;
        int     next_hold_at;
        fault_t want;
        hold_left    = 0;
        next_hold_at = 300;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                results_seen++;
                if (expected_faults.size() == 0) begin
                    log_mismatch($sformatf("result %0d arrived with nothing pending, data %h",
                                           results_seen, m_tdata));
                end else begin
                    want = expected_faults.pop_front();
                    if (m_tdata[0] !== want.bad_clip)
                        log_mismatch($sformatf("result %0d bad_clipping got %b want %b",
                                               results_seen, m_tdata[0], want.bad_clip));
                    if (m_tdata[1] !== want.bad_vert)
                        log_mismatch($sformatf("result %0d bad_vertical got %b want %b",
                                               results_seen, m_tdata[1], want.bad_vert));
                    if (m_tdata[3:2] !== want.lik)
                        log_mismatch($sformatf("result %0d likelihood got %0d want %0d",
                                               results_seen, m_tdata[3:2], want.lik));
                end
            end
            if (hold_left == 0 && results_seen >= next_hold_at && next_hold_at < 1000) begin
                hold_left    = 80;
                next_hold_at = next_hold_at + 400;
            end
            if (hold_left > 0) begin
                m_tready  <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    initial begin : run_limit
        #3_000_000;
        $display("** vertical_accel_fault_monitor: FAILED **");
        $finish;
    end

    initial begin : stimulus
        for (int k = 0; k < NSRC; k++) begin
            src_innov[k]  = '0;
            src_var[k]    = '0;
            src_active[k] = 1'b0;
        end
        for (int ax = 0; ax < AXES; ax++)
            clip_cnt[ax] = '0;
        last_bad_us = '0;
        bad_vert_q  = 1'b0;

        // Directed rows under the reset register values (limit 100, probation 10 s,
        // thresholds 1.0 and 3.0). A positive innovation of 4.0 over a variance of 1.0
        // fails both tests.
        dir_rows.push_back('{imu_beat(3'b000, 64'd0), 1'b1, '{1'b0, 1'b0, LIK_LOW}});
        dir_rows.push_back('{load_beat(3'd0, 1'b1, 32'h0004_0000, 32'h0001_0000),
                             1'b0, NO_TYPED});
        // Only the barometer fails: one reference type gives a medium grade.
        dir_rows.push_back('{imu_beat(3'b000, 64'd100), 1'b1, '{1'b0, 1'b0, LIK_MEDIUM}});
        // Range loaded with -4.0 is stored as +4.0, a second reference type.
        dir_rows.push_back('{load_beat(3'd3, 1'b1, 32'hFFFC_0000, 32'h0001_0000),
                             1'b0, NO_TYPED});
        dir_rows.push_back('{imu_beat(3'b000, 64'd1000), 1'b1, '{1'b0, 1'b1, LIK_HIGH}});
        // Most negative range innovation saturates on negation.
        dir_rows.push_back('{load_beat(3'd3, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF),
                             1'b0, NO_TYPED});
        // Slots past the table are ignored.
        dir_rows.push_back('{load_beat(3'd6, 1'b1, 32'h7FFF_FFFF, 32'd1), 1'b0, NO_TYPED});
        dir_rows.push_back('{load_beat(3'd7, 1'b1, 32'h7FFF_FFFF, 32'd1), 1'b0, NO_TYPED});
        dir_rows.push_back('{load_beat(3'd0, 1'b0, 32'h0004_0000, 32'h0001_0000),
                             1'b0, NO_TYPED});
        dir_rows.push_back('{imu_beat(3'b111, 64'd2000), 1'b0, NO_TYPED});
        // Clock going backwards keeps the fault.
        dir_rows.push_back('{imu_beat(3'b111, 64'd500), 1'b0, NO_TYPED});
        // Far future: probation has run out.
        dir_rows.push_back('{imu_beat(3'b000, 64'hFFFF_FFFF_FFFF_FFFF), 1'b0, NO_TYPED});
        // Zero variance takes no part in the tests.
        dir_rows.push_back('{load_beat(3'd1, 1'b1, 32'h7FFF_FFFF, 32'd0), 1'b0, NO_TYPED});
        dir_rows.push_back('{load_beat(3'd2, 1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF),
                             1'b0, NO_TYPED});
        dir_rows.push_back('{imu_beat(3'b010, 64'hFFFF_FFFF_FFFF_FFFF), 1'b0, NO_TYPED});
        dir_rows.push_back('{load_beat(3'd4, 1'b1, 32'h8000_0000, 32'd1), 1'b0, NO_TYPED});
        dir_rows.push_back('{load_beat(3'd5, 1'b1, 32'd0, 32'd1), 1'b0, NO_TYPED});
        dir_rows.push_back('{load_beat(3'd2, 1'b0, 32'd0, 32'd0), 1'b0, NO_TYPED});
        dir_rows.push_back('{load_beat(3'd3, 1'b1, 32'd0, 32'h0001_0000), 1'b0, NO_TYPED});
        dir_rows.push_back('{imu_beat(3'b100, 64'd0), 1'b0, NO_TYPED});
        dir_rows.push_back('{imu_beat(3'b001, 64'd1), 1'b0, NO_TYPED});
        dir_rows.push_back('{load_beat(3'd4, 1'b1, 32'd1, 32'hFFFF_FFFF), 1'b0, NO_TYPED});
        dir_rows.push_back('{imu_beat(3'b111, 64'd2), 1'b0, NO_TYPED});

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].s, dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_inputs();
            idle_pct = 25;
            case (ph)
                0: begin
                    apply_settings(10'd100, 26'd10000000, 16'd256, 16'd768);
                    clip_bias = 85;
                end
                1: begin
                    // Zero limit marks every axis critical; zero thresholds fail any positive
                    // innovation; zero probation clears a set fault unless time steps back.
                    apply_settings(10'd0, 26'd0, 16'd0, 16'd0);
                    clip_bias = 50;
                end
                2: begin
                    apply_settings(10'd1023, 26'h3FF_FFFF, 16'hFFFF, 16'hFFFF);
                    clip_bias = 95;
                end
                3: begin
                    apply_settings(10'd1, 26'd60000000, 16'd128, 16'd384);
                    clip_bias = 40;
                end
                4: begin
                    // No idling on either side through this phase.
                    apply_settings(10'd20, 26'd5000, 16'd64, 16'd200);
                    clip_bias = 90;
                    idle_pct  = 0;
                end
                5: begin
                    // Counters left near 20 now sit above the new limit.
                    apply_settings(10'd6, 26'd20000, 16'd256, 16'd768);
                    clip_bias = 60;
                end
                default: begin
                    apply_settings(10'($urandom_range(0, 1023)), 26'($urandom),
                                   16'($urandom), 16'($urandom));
                    clip_bias = $urandom_range(10, 95);
                end
            endcase
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                // Once, the sender stops mid-phase until every result is back.
                if (ph == 3 && n == BEATS_PER_PHASE / 2)
                    drain_inputs();
                send_beat(random_beat(), 1'b0, NO_TYPED);
            end
        end

        drain_inputs();
        if (mismatches == 0)
            $display("** vertical_accel_fault_monitor: PASSED **");
        else
            $display("** vertical_accel_fault_monitor: FAILED **");
        $finish;
    end

endmodule
